@@ sv/mm3_pkg.sv @@
// ----------------------------------------------------------------------------
// mm3_pkg
// shared types, constants and helper functions for the murmur3 x86_32 hasher
// ----------------------------------------------------------------------------
`default_nettype none

package mm3_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 3;

    localparam logic [WORD_W-1:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MIX_C2  = 32'h1b873593;
    localparam logic [WORD_W-1:0] MIX_ADD = 32'he6546b64;
    localparam logic [WORD_W-1:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
    localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;

    localparam int QUEUE_DEPTH_DEF = 4;

    // scrambled key as it travels from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_qword;

    // effective byte count: full word unless a short last word
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
                                                   input logic last);
        logic [CNT_W-1:0] res;
        if (!last || (cnt > CNT_FULL)) begin
            res = CNT_FULL;
        end else begin
            res = cnt;
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] tail_mask(input logic [CNT_W-1:0] cnt);
        logic [WORD_W-1:0] res;
        case (cnt)
            CNT_NONE:  res = 32'h0000_0000;
            CNT_ONE:   res = 32'h0000_00ff;
            CNT_TWO:   res = 32'h0000_ffff;
            CNT_THREE: res = 32'h00ff_ffff;
            default:   res = 32'hffff_ffff;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
        return {x[18:0], x[31:19]};
    endfunction

endpackage

`default_nettype wire

@@ sv/mm3_channels.sv @@
// ----------------------------------------------------------------------------
// mm3 channels
// valid/ready interfaces for the word input, the hash output and the seed write
// ----------------------------------------------------------------------------
`default_nettype none

interface mm3_item_if import mm3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic [CNT_W-1:0]  byte_count;
    logic              last_item;

    modport source (output valid, output data_word, output byte_count,
                    output last_item, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input last_item, output ready);
endinterface

interface mm3_hash_if import mm3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface mm3_seed_if import mm3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

`default_nettype wire

@@ sv/mm3_front.sv @@
// ----------------------------------------------------------------------------
// mm3_front
// accepts words, masks the tail and runs the two-multiply key scramble
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_front
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mm3_item_if.sink              i_item,
    input  wire logic [LVL_W-1:0] i_level,
    output logic                  o_push,
    output t_qword                o_qword
);

    localparam int SUM_W = $clog2(QUEUE_DEPTH + 3);

    logic              r_s1_v;
    logic [WORD_W-1:0] r_s1_key;
    logic [CNT_W-1:0]  r_s1_cnt;
    logic              r_s1_last;
    logic              r_s2_v;
    t_qword            r_s2;

    logic [SUM_W-1:0]  w_used;
    logic              w_take;
    logic [CNT_W-1:0]  w_cnt;

    // queue entries plus words still in the scramble stages
    assign w_used = SUM_W'(i_level) + SUM_W'(r_s1_v) + SUM_W'(r_s2_v);
    assign i_item.ready = (w_used < SUM_W'(QUEUE_DEPTH));
    assign w_take = i_item.valid && i_item.ready;
    assign w_cnt  = eff_count(i_item.byte_count, i_item.last_item);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_take;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_key  <= (i_item.data_word & tail_mask(w_cnt)) * MIX_C1;
        r_s1_cnt  <= w_cnt;
        r_s1_last <= i_item.last_item;
        r_s2.key  <= rotl15(r_s1_key) * MIX_C2;
        r_s2.cnt  <= r_s1_cnt;
        r_s2.last <= r_s1_last;
    end

    assign o_push  = r_s2_v;
    assign o_qword = r_s2;

endmodule

`default_nettype wire

@@ sv/mm3_queue.sv @@
// ----------------------------------------------------------------------------
// mm3_queue
// short fifo of scrambled keys between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_queue
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_qword           i_qword,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output t_qword                o_qword,
    output logic [LVL_W-1:0]      o_level
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_qword             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [LVL_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_qword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_qword = r_mem[r_rd];
    assign o_level = r_count;

    // the front only sends a word when it has reserved a slot
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != LVL_W'(QUEUE_DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && i_pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count lost a pop");

endmodule

`default_nettype wire

@@ sv/mm3_back.sv @@
// ----------------------------------------------------------------------------
// mm3_back
// running hash recurrence, length count and the three-stage final avalanche
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_back
    import mm3_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [WORD_W-1:0] i_seed,
    input  wire logic              i_q_valid,
    input  wire t_qword            i_qword,
    output logic                   o_pop,
    mm3_hash_if.source             o_hash
);

    logic [WORD_W-1:0] r_hash;
    logic [WORD_W-1:0] r_total;
    logic              r_in_msg;

    logic              r_f0_v;
    logic              r_f1_v;
    logic              r_f2_v;
    logic [WORD_W-1:0] r_f0;
    logic [WORD_W-1:0] r_f1;
    logic [WORD_W-1:0] r_f2;

    logic              w_f2_free;
    logic              w_f1_free;
    logic              w_f0_free;
    logic [WORD_W-1:0] w_h0;
    logic [WORD_W-1:0] w_h1;
    logic [WORD_W-1:0] w_rot;
    logic [WORD_W-1:0] n_hash;
    logic [WORD_W-1:0] n_total;
    logic [WORD_W-1:0] w_f0_mix;
    logic [WORD_W-1:0] w_f1_mix;

    assign w_f2_free = !r_f2_v || o_hash.ready;
    assign w_f1_free = !r_f1_v || w_f2_free;
    assign w_f0_free = !r_f0_v || w_f1_free;

    // a last word waits until the finalizer can take it
    assign o_pop = i_q_valid && (!i_qword.last || w_f0_free);

    always_comb begin
        w_h0    = r_in_msg ? r_hash : i_seed;
        w_h1    = w_h0 ^ i_qword.key;
        w_rot   = rotl13(w_h1);
        n_total = (r_in_msg ? r_total : '0) + WORD_W'(i_qword.cnt);
        if (i_qword.cnt == CNT_FULL) begin
            // times five as shift and add
            n_hash = w_rot + {w_rot[WORD_W-3:0], 2'b00} + MIX_ADD;
        end else begin
            n_hash = w_h1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_total  <= '0;
            r_in_msg <= 1'b0;
        end else if (o_pop) begin
            r_hash   <= n_hash;
            r_total  <= n_total;
            r_in_msg <= !i_qword.last;
        end
    end

    assign w_f0_mix = r_f0 ^ (r_f0 >> 16);
    assign w_f1_mix = r_f1 ^ (r_f1 >> 13);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            if (w_f2_free) begin
                r_f2_v <= r_f1_v;
            end
            if (w_f1_free) begin
                r_f1_v <= r_f0_v;
            end
            if (w_f0_free) begin
                r_f0_v <= o_pop && i_qword.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f2_free) begin
            r_f2 <= w_f1_mix * FIN_M2;
        end
        if (w_f1_free) begin
            r_f1 <= w_f0_mix * FIN_M1;
        end
        if (w_f0_free) begin
            r_f0 <= n_hash ^ n_total;
        end
    end

    assign o_hash.valid      = r_f2_v;
    assign o_hash.hash_value = r_f2 ^ (r_f2 >> 16);

endmodule

`default_nettype wire

@@ sv/murmur3_hash_32.sv @@
// ----------------------------------------------------------------------------
// murmur3_hash_32
// streaming 32-bit murmur3 (x86_32) hasher over little-endian message words
// ----------------------------------------------------------------------------
// i_item carries one word per handshake: data_word, byte_count and last_item.
// words before the last are always taken as four bytes; the last word may
// hold 0 to 4 bytes (5..7 count as 4). o_hash delivers one hash_value per
// message, after its last word. i_seed writes the seed, which is loaded at the
// start of every message; write it only while no message is in flight.
// the block takes one word per cycle while the queue has room: the key
// scramble runs in a two-stage front pipeline, a short queue follows, and
// the back does one hash step per cycle (xor, rotate, times five, add) unless
// a last word waits for the finalizer. a result leaves through three finalizer
// stages after its last word. back-to-back messages run at full rate.
// while o_hash is stalled the finalizer holds up to three hashes; the back
// then stops only at a last word, and the front keeps taking words until the
// queue plus scramble stages hold QUEUE_DEPTH words.
// reset clears the seed, the running hash, the length and all valid flags;
// the next word after reset starts a new message.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur3_hash_32
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mm3_item_if.sink  i_item,
    mm3_seed_if.sink  i_seed,
    mm3_hash_if.source o_hash
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WORD_W-1:0] r_seed;
    logic              w_push;
    t_qword            w_push_word;
    logic              w_q_valid;
    t_qword            w_q_word;
    logic              w_pop;
    logic [LVL_W-1:0]  w_level;

    assign i_seed.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_seed.valid) begin
            r_seed <= i_seed.seed;
        end
    end

    mm3_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LVL_W       (LVL_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_level (w_level),
        .o_push  (w_push),
        .o_qword (w_push_word)
    );

    mm3_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LVL_W       (LVL_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_qword (w_push_word),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_qword (w_q_word),
        .o_level (w_level)
    );

    mm3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_q_valid (w_q_valid),
        .i_qword   (w_q_word),
        .o_pop     (w_pop),
        .o_hash    (o_hash)
    );

endmodule

`default_nettype wire
